// File: rtl/olist_pkg.sv
`default_nettype none
package olist_pkg;
   localparam int DefaultListDepth = 256;
   localparam int ValueWidth = 32;
   localparam int PosWidth = 8;
   localparam int CountWidth = 9;

   typedef enum logic [1:0] {
      MODE_INS_FRONT = 2'd0,
      MODE_INS_BACK  = 2'd1,
      MODE_DELETE    = 2'd2,
      MODE_SEARCH    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_POS   = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, start at front
      logic rd;        // read current slot
      logic step;      // advance along forward link
      logic ins;       // perform insert
      logic del;       // perform delete of current slot
      logic init_step; // free stack init write
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic pos_bad;
      logic at_pos;    // walk index reached delete position
      logic match;     // current slot value equals key
      logic walk_end;  // walk index reached length
      logic init_done;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/ordered_list_engine_unit.sv
// Ordered list engine: a bounded doubly linked list of signed 32-bit values
// held in slot memories. After reset the free-slot stack is filled with every
// slot index before the first request is taken. Inserts complete without a
// walk; delete and search walk the forward links element by element, through
// the single registered read port of the link memory. One request is in
// flight at a time and its result is held until taken.
`default_nettype none
module ordered_list_engine_unit #(
   parameter int LIST_DEPTH = olist_pkg::DefaultListDepth
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [1:0] req_mode,
   input  wire logic signed [31:0] req_value,
   input  wire logic [7:0] req_position,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic rsp_found,
   output logic [7:0] rsp_found_position,
   output logic [8:0] rsp_element_count
);
   import olist_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic [7:0] walk_pos;
   logic [8:0] count;

   olist_datapath #(.ListDepth(LIST_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_mode, .req_value(req_value), .req_position,
      .walk_pos, .count_out(count)
   );

   olist_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_mode,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_found, .rsp_found_position,
      .rsp_element_count, .cmd, .sts, .walk_pos, .count_in(count)
   );
endmodule
`default_nettype wire

// File: rtl/olist_datapath.sv
`default_nettype none
module olist_datapath #(
   parameter int ListDepth = olist_pkg::DefaultListDepth
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire olist_pkg::cmd_type cmd,
   output olist_pkg::sts_type sts,
   input  wire logic [1:0] req_mode,
   input  wire logic [31:0] req_value,
   input  wire logic [7:0] req_position,
   output logic [7:0] walk_pos,
   output logic [8:0] count_out
);
   import olist_pkg::*;
   localparam int SW = (ListDepth > 1) ? $clog2(ListDepth) : 1;
   localparam int CW = $clog2(ListDepth + 1);
   localparam int MW = (CW > 8) ? CW : 8;

   logic [ValueWidth-1:0] val_mem [ListDepth];
   logic [SW-1:0] fwd_mem [ListDepth];
   logic [SW-1:0] bwd_mem [ListDepth];
   logic [SW-1:0] free_mem [ListDepth];

   logic [SW-1:0] front_ff, back_ff, cur_ff, next_ff, prev_ff;
   logic [CW-1:0] len_ff, top_ff, idx_ff, init_ff;
   logic [ValueWidth-1:0] key_ff, curval_ff;
   logic [7:0] pos_ff;
   logic [SW-1:0] free_rd_ff;
   logic ins_front_ff;
   logic init_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff <= '0;
         len_ff <= '0;
         top_ff <= CW'(ListDepth);
         init_ff <= '0;
         init_done_ff <= 1'b0;
      end else begin
         if (cmd.init_step) begin
            free_mem[init_ff[SW-1:0]] <= init_ff[SW-1:0];
            init_ff <= init_ff + 1'b1;
            if (init_ff == CW'(ListDepth - 1)) init_done_ff <= 1'b1;
         end
         if (cmd.ins) begin
            // free_rd_ff holds slot at top-1, read during load
            val_mem[free_rd_ff] <= key_ff;
            top_ff <= top_ff - 1'b1;
            len_ff <= len_ff + 1'b1;
            if (len_ff == '0) begin
               front_ff <= free_rd_ff;
               back_ff <= free_rd_ff;
            end else if (ins_front_ff) begin
               fwd_mem[free_rd_ff] <= front_ff;
               bwd_mem[front_ff] <= free_rd_ff;
               front_ff <= free_rd_ff;
            end else begin
               bwd_mem[free_rd_ff] <= back_ff;
               fwd_mem[back_ff] <= free_rd_ff;
               back_ff <= free_rd_ff;
            end
         end
         if (cmd.del) begin
            if (len_ff == CW'(1)) begin
               front_ff <= '0;
               back_ff <= '0;
            end else if (cur_ff == front_ff) begin
               front_ff <= next_ff;
            end else if (cur_ff == back_ff) begin
               back_ff <= prev_ff;
            end else begin
               fwd_mem[prev_ff] <= next_ff;
               bwd_mem[next_ff] <= prev_ff;
            end
            free_mem[top_ff[SW-1:0]] <= cur_ff;
            top_ff <= top_ff + 1'b1;
            len_ff <= len_ff - 1'b1;
         end
      end
   end

   // walk pointer and registered reads
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_value;
         pos_ff <= req_position;
         ins_front_ff <= (req_mode == MODE_INS_FRONT);
         cur_ff <= front_ff;
         idx_ff <= '0;
         free_rd_ff <= free_mem[top_ff[SW-1:0] - 1'b1];
      end else if (cmd.step) begin
         cur_ff <= next_ff;
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.rd) begin
         curval_ff <= val_mem[cur_ff];
         next_ff <= fwd_mem[cur_ff];
         prev_ff <= bwd_mem[cur_ff];
      end
   end

   assign sts.full = (len_ff >= CW'(ListDepth));
   assign sts.pos_bad = (MW'(pos_ff) >= MW'(len_ff));
   assign sts.at_pos = ({{CW{1'b0}}, pos_ff} == {8'd0, idx_ff});
   assign sts.match = (curval_ff == key_ff);
   assign sts.walk_end = (idx_ff == len_ff);
   assign sts.init_done = init_done_ff;
   assign walk_pos = 8'(idx_ff);
   assign count_out = 9'(len_ff);
endmodule
`default_nettype wire

// File: rtl/olist_ctrl.sv
`default_nettype none
module olist_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [1:0] req_mode,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic rsp_found,
   output logic [7:0] rsp_found_position,
   output logic [8:0] rsp_element_count,
   output olist_pkg::cmd_type cmd,
   input  wire olist_pkg::sts_type sts,
   input  wire logic [7:0] walk_pos,
   input  wire logic [8:0] count_in
);
   import olist_pkg::*;
   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_DISPATCH, S_READ, S_CHECK, S_FINISH, S_RESP
   } state_type;

   state_type state_ff;
   logic [1:0] mode_ff, status_ff;
   logic found_ff;
   logic [7:0] fpos_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_INIT:     cmd.init_step = !sts.init_done;
         S_IDLE:     cmd.load = req_valid;
         S_DISPATCH: cmd.rd = 1'b1;
         S_READ:     cmd.rd = 1'b1;
         S_CHECK:    cmd.step = !((mode_ff == MODE_DELETE) ? sts.at_pos
                                   : (sts.walk_end || sts.match));
         default:    ;
      endcase
      if (state_ff == S_DISPATCH && (mode_ff == MODE_INS_FRONT || mode_ff == MODE_INS_BACK)
          && !sts.full) cmd.ins = 1'b1;
      if (state_ff == S_FINISH && mode_ff == MODE_DELETE && status_ff == STATUS_DONE)
         cmd.del = 1'b1;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_found = found_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_element_count = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         mode_ff <= '0;
         status_ff <= STATUS_DONE;
         found_ff <= 1'b0;
         fpos_ff <= '0;
      end else begin
         unique case (state_ff)
            S_INIT: if (sts.init_done) state_ff <= S_IDLE;
            S_IDLE: if (req_valid) begin
               mode_ff <= req_mode;
               status_ff <= STATUS_DONE;
               found_ff <= 1'b0;
               fpos_ff <= '0;
               state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               case (mode_ff)
                  MODE_INS_FRONT, MODE_INS_BACK: begin
                     if (sts.full) status_ff <= STATUS_FULL;
                     state_ff <= S_RESP;
                  end
                  MODE_DELETE: if (sts.pos_bad) begin
                     status_ff <= STATUS_NO_POS;
                     state_ff <= S_RESP;
                  end else state_ff <= S_READ;
                  default: state_ff <= S_READ;
               endcase
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (mode_ff == MODE_DELETE) begin
                  if (sts.at_pos) state_ff <= S_FINISH;
                  else state_ff <= S_DISPATCH;
               end else if (sts.walk_end) state_ff <= S_RESP;
               else if (sts.match) begin
                  found_ff <= 1'b1;
                  fpos_ff <= walk_pos;
                  state_ff <= S_RESP;
               end else state_ff <= S_DISPATCH;
            end
            S_FINISH: state_ff <= S_RESP;
            S_RESP: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("held beat changed");
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins && cmd.del)) else $error("insert and delete together");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> mode_ff == MODE_SEARCH)
      else $error("found outside search");
endmodule
`default_nettype wire

// File: bench/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import olist_pkg::*;

   localparam int Depth = 256;

   typedef struct packed {
      mode_type mode;
      logic signed [31:0] value;
      logic [7:0] position;
   } request_type;

   typedef struct packed {
      status_type status;
      logic found;
      logic [7:0] found_position;
      logic [8:0] element_count;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic signed [31:0] req_value = '0;
   logic [7:0] req_position = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_found;
   logic [7:0] rsp_found_position;
   logic [8:0] rsp_element_count;

   ordered_list_engine_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_value(req_value), .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_found(rsp_found), .rsp_found_position(rsp_found_position),
      .rsp_element_count(rsp_element_count)
   );

   // list contents in order, front first
   logic signed [31:0] list_contents[$];
   request_type pending_requests[$];
   answer_type expected_answers[$];
   int mismatch_count = 0;
   int sent_count = 0;
   bit req_accepted = 1'b0;
   bit quiet_phase = 1'b0;
   bit hold_sender = 1'b0;
   int hold_receiver = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic answer_type apply_request(request_type r);
      answer_type a;
      a = '{status: STATUS_DONE, found: 1'b0, found_position: '0, element_count: '0};
      case (r.mode)
         MODE_INS_FRONT, MODE_INS_BACK: begin
            if (list_contents.size() >= Depth) a.status = STATUS_FULL;
            else if (r.mode == MODE_INS_FRONT) list_contents.push_front(r.value);
            else list_contents.push_back(r.value);
         end
         MODE_DELETE: begin
            if (r.position >= list_contents.size()) a.status = STATUS_NO_POS;
            else list_contents.delete(r.position);
         end
         default: begin
            foreach (list_contents[i]) begin
               if (!a.found && list_contents[i] == r.value) begin
                  a.found = 1'b1;
                  a.found_position = 8'(i);
               end
            end
         end
      endcase
      a.element_count = 9'(list_contents.size());
      return a;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_requests.size() > 0 && !hold_sender
               && (quiet_phase || $urandom_range(99) >= 15)) begin
            request_type r;
            r = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_mode <= r.mode;
            req_value <= r.value;
            req_position <= r.position;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_receiver > 0) begin
         rsp_stall <= 1'b1;
         hold_receiver <= hold_receiver - 1;
      end else begin
         rsp_stall <= !quiet_phase && $urandom_range(99) < 15;
      end
   end

   // monitor
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_answers.push_back(apply_request(
               '{mode: mode_type'(req_mode), value: req_value, position: req_position}));
            sent_count <= sent_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) $display("unexpected result beat");
            end else begin
               answer_type e;
               e = expected_answers.pop_front();
               if (rsp_status !== e.status || rsp_found !== e.found
                     || rsp_found_position !== e.found_position
                     || rsp_element_count !== e.element_count) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                        e.status, e.found, e.found_position, e.element_count,
                        rsp_status, rsp_found, rsp_found_position, rsp_element_count);
               end
            end
         end
      end
   end

   task automatic queue_request(mode_type m, logic signed [31:0] v, logic [7:0] p);
      pending_requests.push_back('{mode: m, value: v, position: p});
   endtask

   // values drawn from a small pool so searches hit, with occasional wide ones
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(3) == 0) return $urandom;
      return $signed(32'($urandom_range(15))) - 8;
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int k;
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed
      queue_request(MODE_DELETE, 0, 8'd0);
      queue_request(MODE_SEARCH, 0, 8'd0);
      queue_request(MODE_INS_FRONT, 32'sh7fffffff, 8'hff);
      queue_request(MODE_DELETE, 0, 8'd0);
      queue_request(MODE_INS_BACK, 32'sh80000000, 8'd0);
      queue_request(MODE_INS_FRONT, -1, 8'd0);
      queue_request(MODE_INS_BACK, 0, 8'd0);
      queue_request(MODE_INS_BACK, -1, 8'd0);
      queue_request(MODE_SEARCH, -1, 8'd0);
      queue_request(MODE_SEARCH, 0, 8'd0);
      queue_request(MODE_SEARCH, 32'sh80000000, 8'd0);
      queue_request(MODE_SEARCH, 5, 8'd0);
      queue_request(MODE_DELETE, 0, 8'd4);
      queue_request(MODE_DELETE, 0, 8'hff);
      queue_request(MODE_DELETE, 0, 8'd1);
      queue_request(MODE_DELETE, 0, 8'd2);
      queue_request(MODE_DELETE, 0, 8'd0);
      queue_request(MODE_DELETE, 0, 8'd0);
      queue_request(MODE_DELETE, 0, 8'd0);
      wait_drained();
      // fill to capacity, with the receiver holding off at first, then overflow
      hold_receiver = 400;
      for (k = 0; k < Depth + 3; k++)
         queue_request(k[0] ? MODE_INS_BACK : MODE_INS_FRONT, pick_value(), '0);
      queue_request(MODE_SEARCH, 32'sh12345678, 8'd0);
      queue_request(MODE_DELETE, 0, 8'd255);
      queue_request(MODE_DELETE, 0, 8'd255);
      queue_request(MODE_INS_BACK, 32'sh7fffffff, 8'd0);
      queue_request(MODE_SEARCH, 32'sh7fffffff, 8'd0);
      for (k = 0; k < 200; k++)
         queue_request(MODE_DELETE, 0, 8'($urandom_range(255)));
      wait_drained();
      // sender pauses until all answers are back
      hold_sender = 1'b1;
      wait_drained();
      hold_sender = 1'b0;
      // random mix, with a quiet stretch in the middle
      for (n = 0; n < 280; n++) begin
         k = $urandom_range(9);
         if (n == 100) begin
            wait_drained();
            quiet_phase = 1'b1;
         end
         if (n == 160) begin
            wait_drained();
            quiet_phase = 1'b0;
         end
         if (k < 3) queue_request(MODE_INS_FRONT, pick_value(), 8'($urandom));
         else if (k < 6) queue_request(MODE_INS_BACK, pick_value(), 8'($urandom));
         else if (k < 8)
            queue_request(MODE_DELETE, pick_value(),
               $urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(40)));
         else queue_request(MODE_SEARCH, pick_value(), 8'($urandom));
      end
      wait_drained();
      repeat (1000) @(posedge clock);
      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("ordered_list_engine_unit test passed");
      else
         $display("ordered_list_engine_unit test failed");
      $finish;
   end

   initial begin
      #10ms;
      $display("ordered_list_engine_unit test failed");
      $finish;
   end
endmodule
`default_nettype wire

// File: ordered_list_engine_unit.f
rtl/olist_pkg.sv
rtl/olist_datapath.sv
rtl/olist_ctrl.sv
rtl/ordered_list_engine_unit.sv
bench/testbench.sv
